// File: design/dhcpx_pkg.sv
// Shared types, constants and helpers for the DHCP option extractor.
package dhcpx_pkg;

  localparam int MAX_PARAMS_DEF        = 32;
  localparam int LINK_HEADER_BYTES_DEF = 14;

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_REQ_ADDR  = 8'd50;
  localparam logic [7:0] OPT_PARAM_REQ = 8'h37;
  localparam logic [7:0] OPT_END       = 8'd255;
  localparam logic [7:0] COOKIE_FIRST  = 8'h63;
  localparam int         UDP_HDR_BYTES = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [31:0] requested_ip;
    logic [7:0]  param_code;
    logic [5:0]  param_count;
    logic        run_last;
  } out_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_COOKIE = 3'd1,
    PH_CODE   = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EM_PARSE = 2'd0,
    EM_READ  = 2'd1,
    EM_LOAD  = 2'd2
  } emit_state_t;

  // Summary of a frame whose last byte was just taken.
  typedef struct packed {
    logic        done;
    logic        emit;
    logic [31:0] ip;
  } frame_end_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h63;
      2'd1: b = 8'h82;
      2'd2: b = 8'h53;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

// File: design/dhcpx_code_ram.sv
// Code store: one write port, one registered read port.
module dhcpx_code_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/dhcpx_parser.sv
// Byte-serial frame parser: header skip, cookie search and option walk.
module dhcpx_parser #(
  parameter int MAX_PARAMS        = 32,
  parameter int LINK_HEADER_BYTES = 14,
  parameter int AW                = 5,
  parameter int CW                = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  dhcpx_pkg::in_t         in_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [7:0]             wr_data,
  output dhcpx_pkg::frame_end_t  fe,
  output logic [CW-1:0]          fe_count
);
  import dhcpx_pkg::*;

  localparam logic [16:0] LINK_POS = 17'(LINK_HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);

  phase_t       phase_r, phase_nxt;
  logic [15:0]  pos_r, pos_nxt;
  logic [3:0]   ihl_r, ihl_nxt;
  logic [1:0]   cookie_r, cookie_nxt;
  logic [7:0]   opt_r, opt_nxt;
  logic [7:0]   left_r, left_nxt;
  logic [31:0]  addr_r, addr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]   found_r, found_nxt;

  logic [7:0]   b;
  logic [3:0]   ihl_eff;
  logic [16:0]  start_pos;
  logic [7:0]   left_dec;

  function automatic logic [1:0] mark_found(input logic [7:0] opt, input logic [1:0] f);
    logic [1:0] r;
    r = f;
    if (opt == OPT_REQ_ADDR) begin
      r[0] = 1'b1;
    end else if (opt == OPT_PARAM_REQ) begin
      r[1] = 1'b1;
    end
    return r;
  endfunction

  assign b         = in_data.data_byte;
  assign ihl_eff   = ({1'b0, pos_r} == LINK_POS) ? b[3:0] : ihl_r;
  assign start_pos = LINK_POS + {11'd0, ihl_eff, 2'b00} + 17'(UDP_HDR_BYTES);
  assign left_dec  = left_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    ihl_nxt    = ihl_r;
    cookie_nxt = cookie_r;
    opt_nxt    = opt_r;
    left_nxt   = left_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = b;

    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          ihl_nxt = ihl_eff;
          if ({1'b0, pos_r} + 17'd1 == start_pos) begin
            phase_nxt = PH_COOKIE;
          end
        end
        PH_COOKIE: begin
          if (b == cookie_byte(cookie_r)) begin
            if (cookie_r == 2'd3) begin
              cookie_nxt = 2'd0;
              phase_nxt  = PH_CODE;
            end else begin
              cookie_nxt = cookie_r + 2'd1;
            end
          end else if (b == COOKIE_FIRST) begin
            cookie_nxt = 2'd1;
          end else if (b == OPT_END) begin
            cookie_nxt = 2'd0;
            phase_nxt  = PH_DONE;
          end else begin
            cookie_nxt = 2'd0;
          end
        end
        PH_CODE: begin
          if (b == OPT_END) begin
            phase_nxt = PH_DONE;
          end else if (b != OPT_PAD) begin
            opt_nxt   = b;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (opt_r == OPT_REQ_ADDR) begin
            addr_nxt = '0;
          end else if (opt_r == OPT_PARAM_REQ) begin
            cnt_nxt = '0;
          end
          left_nxt = b;
          if (b == 8'd0) begin
            found_nxt = mark_found(opt_r, found_r);
            phase_nxt = (found_nxt == 2'b11) ? PH_DONE : PH_CODE;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (opt_r == OPT_REQ_ADDR) begin
            addr_nxt = {addr_r[23:0], b};
          end else if (opt_r == OPT_PARAM_REQ) begin
            if (cnt_r < CNT_MAX) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            found_nxt = mark_found(opt_r, found_r);
            phase_nxt = (found_nxt == 2'b11) ? PH_DONE : PH_CODE;
          end
        end
        default: begin
        end
      endcase
      if (pos_r != 16'hFFFF) begin
        pos_nxt = pos_r + 16'd1;
      end
    end
  end

  assign fe.done  = in_fire && in_data.frame_last;
  assign fe.emit  = (found_nxt == 2'b11);
  assign fe.ip    = addr_nxt;
  assign fe_count = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || fe.done) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      ihl_r    <= '0;
      cookie_r <= '0;
      opt_r    <= '0;
      left_r   <= '0;
      addr_r   <= '0;
      cnt_r    <= '0;
      found_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      ihl_r    <= ihl_nxt;
      cookie_r <= cookie_nxt;
      opt_r    <= opt_nxt;
      left_r   <= left_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
    end
  end

endmodule

// File: design/dhcp_option_extractor_unit.sv
// Top level of the DHCP option extractor: parser, code store and result burst.
// Frame bytes are taken one per cycle while parsing; each byte is consumed the cycle it arrives.
// After a frame's last byte with both options seen, the result burst starts: the first code is read
// from the store (unless the code list is empty), then one result per cycle while out_ready is high.
// No request is taken during the burst. A frame without both options starts no burst.
// Reset (rst_n low, synchronous) clears the parse state and the burst sequencer; the code store is not cleared.
module dhcp_option_extractor_unit #(
  parameter int MAX_PARAMS        = dhcpx_pkg::MAX_PARAMS_DEF,
  parameter int LINK_HEADER_BYTES = dhcpx_pkg::LINK_HEADER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dhcpx_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dhcpx_pkg::out_t out_data
);
  import dhcpx_pkg::*;

  // Address width of the code store and width of the code count (which can reach MAX_PARAMS).
  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);

  logic          in_fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  frame_end_t    fe;
  logic [CW-1:0] fe_count;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  emit_state_t   state_r, state_nxt;
  logic [31:0]   ip_r, ip_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  out_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          list_empty;
  logic [CW-1:0] idx_inc;
  logic          is_last;
  logic          can_load;

  // Requests are taken only while the sequencer is not draining a burst.
  assign in_ready = (state_r == EM_PARSE);
  assign in_fire  = in_valid && in_ready;

  dhcpx_parser #(
    .MAX_PARAMS        (MAX_PARAMS),
    .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
    .AW                (AW),
    .CW                (CW)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .fe       (fe),
    .fe_count (fe_count)
  );

  dhcpx_code_ram #(
    .DEPTH (MAX_PARAMS),
    .AW    (AW)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign list_empty = (cnt_r == '0);
  assign idx_inc    = idx_r + CW'(1);
  assign is_last    = list_empty || (idx_inc == cnt_r);
  // The output register takes a new result when it is empty or being drained.
  assign can_load   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    ip_nxt        = ip_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];

    unique case (state_r)
      EM_PARSE: begin
        // Frame end with both options: latch the summary and start the burst.
        // The read is issued from EM_READ so that a code written with the last byte is already in the store.
        if (fe.done && fe.emit) begin
          ip_nxt    = fe.ip;
          cnt_nxt   = fe_count;
          idx_nxt   = '0;
          state_nxt = (fe_count == '0) ? EM_LOAD : EM_READ;
        end
      end
      EM_READ: begin
        rd_en     = 1'b1;
        state_nxt = EM_LOAD;
      end
      EM_LOAD: begin
        // Store data for idx_r is held in the read register until it is moved out.
        if (can_load) begin
          out_nxt.requested_ip = ip_r;
          out_nxt.param_code   = list_empty ? 8'd0 : rd_data;
          out_nxt.param_count  = 6'(cnt_r);
          out_nxt.run_last     = is_last;
          out_valid_nxt        = 1'b1;
          if (is_last) begin
            state_nxt = EM_PARSE;
          end else begin
            // Prefetch the next code so that results can leave back to back.
            idx_nxt = idx_inc;
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = EM_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_PARSE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r  <= ip_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
